// ===== sv/ohlcv_pkg.sv =====
// ----------------------------------------------------------------------------
// OHLCV bar aggregator package
// Shared widths, reset values, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package ohlcv_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int PRICE_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int VOL_IN_BITS     = 48;
  localparam int VOL_SUM_BITS    = 64;
  localparam int INTERVAL_BITS   = 17;
  localparam int MIN_TICKS_BITS  = 8;

  // Milliseconds per second, and the widest interval in milliseconds:
  // (2^17 - 1) * 1000 < 2^27.
  localparam int MS_PER_SEC      = 1000;
  localparam int IMS_BITS        = 27;

  localparam logic [INTERVAL_BITS-1:0]  INTERVAL_RESET  = INTERVAL_BITS'(60);
  localparam logic [MIN_TICKS_BITS-1:0] MIN_TICKS_RESET = MIN_TICKS_BITS'(3);

  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = INTERVAL_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INTERVAL  = 1'b0,
    CFG_MIN_TICKS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // Status of the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/ohlcv_mod_div.sv =====
// ----------------------------------------------------------------------------
// OHLCV serial remainder unit
// Restoring division, one dividend bit per cycle, keeping only the remainder.
// ----------------------------------------------------------------------------
module ohlcv_mod_div #(
  parameter int TIME_BITS = ohlcv_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [TIME_BITS-1:0]          dividend,
  input  logic [ohlcv_pkg::IMS_BITS-1:0] divisor,
  output logic [ohlcv_pkg::IMS_BITS-1:0] rem,
  output ohlcv_pkg::div_stat_t          stat
);
  import ohlcv_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] num_r, num_nxt;
  logic [IMS_BITS-1:0]  den_r, den_nxt;
  logic [IMS_BITS-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [IMS_BITS:0]    trial;

  // The partial remainder stays below the divisor, so the shifted trial value
  // stays below twice the divisor and a single subtract restores it.
  assign trial = {rem_r, num_r[TIME_BITS-1]};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(TIME_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[TIME_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = IMS_BITS'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[IMS_BITS-1:0];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/ohlcv_bar_aggregator.sv =====
// ----------------------------------------------------------------------------
// OHLCV bar aggregator
// Groups time-ordered price ticks into interval-aligned open/high/low/close
// bars with summed volume and tick count, and answers reads of the open bar.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Beat contents
//  in_      input      in_valid / in_stall  func, tick time, price, volume
//  out_     output     out_valid / out_stall  one bar: start, OHLC, volume,
//                                           count, sparse, snapshot
//  cfg_     input      cfg_valid / cfg_ready  register index and write data
//
//  For a tick beat, the bar start is found by a serial remainder unit that
//  retires one timestamp bit a cycle; the S_ALIGN state then aligns it and
//  the S_APPLY state updates the bar. A read beat is answered in the S_READ
//  state. Reset is synchronous and active low; it closes the open bar and
//  restores the register defaults. A stalled output holds the block only
//  when a new result must be written behind it.
//
module ohlcv_bar_aggregator #(
  parameter int TIME_BITS  = ohlcv_pkg::TIME_BITS_DEF,
  parameter int PRICE_BITS = ohlcv_pkg::PRICE_BITS_DEF,
  parameter int COUNT_BITS = ohlcv_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [TIME_BITS-1:0]               in_tick_ms,
  input  logic [PRICE_BITS-1:0]              in_price,
  input  logic [ohlcv_pkg::VOL_IN_BITS-1:0]  in_volume,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [TIME_BITS-1:0]               out_bar_origin_ms,
  output logic [PRICE_BITS-1:0]              out_open_price,
  output logic [PRICE_BITS-1:0]              out_high_price,
  output logic [PRICE_BITS-1:0]              out_low_price,
  output logic [PRICE_BITS-1:0]              out_close_price,
  output logic [ohlcv_pkg::VOL_SUM_BITS-1:0] out_volume_sum,
  output logic [COUNT_BITS-1:0]              out_tick_count,
  output logic                               out_sparse,
  output logic                               out_snapshot,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ohlcv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ohlcv_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ohlcv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ALIGN,
    S_APPLY,
    S_READ
  } state_t;

  state_t state_r;

  // Configuration registers. The port never pushes back.
  logic [INTERVAL_BITS-1:0]  interval_r;
  logic [MIN_TICKS_BITS-1:0] min_ticks_r;

  // Captured input beat.
  logic                   func_r;
  logic [TIME_BITS-1:0]   ts_r;
  logic [PRICE_BITS-1:0]  price_r;
  logic [VOL_IN_BITS-1:0] vol_r;
  logic [TIME_BITS-1:0]   aligned_r;

  // Open bar.
  logic                    bar_active_r;
  logic [TIME_BITS-1:0]    bar_start_r;
  logic [PRICE_BITS-1:0]   bar_open_r;
  logic [PRICE_BITS-1:0]   bar_high_r;
  logic [PRICE_BITS-1:0]   bar_low_r;
  logic [PRICE_BITS-1:0]   bar_close_r;
  logic [VOL_SUM_BITS-1:0] bar_volume_r;
  logic [COUNT_BITS-1:0]   bar_count_r;

  // Output register.
  logic                    out_valid_r;
  logic [TIME_BITS-1:0]    o_start_r;
  logic [PRICE_BITS-1:0]   o_open_r;
  logic [PRICE_BITS-1:0]   o_high_r;
  logic [PRICE_BITS-1:0]   o_low_r;
  logic [PRICE_BITS-1:0]   o_close_r;
  logic [VOL_SUM_BITS-1:0] o_volume_r;
  logic [COUNT_BITS-1:0]   o_count_r;
  logic                    o_sparse_r;
  logic                    o_snapshot_r;

  logic                      in_acc;
  logic                      slot_free;
  logic                      out_load;
  logic                      div_start;
  logic [INTERVAL_BITS-1:0]  secs;
  logic [IMS_BITS-1:0]       ims;
  logic [IMS_BITS-1:0]       div_rem;
  div_stat_t                 div_stat;
  logic [VOL_SUM_BITS:0]     vol_add;
  logic                      bar_sparse;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The output register can take a new bar when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  // A new bar enters the output register on a read, or when a tick closes
  // the open bar by falling in a later interval.
  assign out_load  = slot_free &&
                     ((state_r == S_READ) ||
                      (state_r == S_APPLY && bar_active_r && (aligned_r > bar_start_r)));

  // An interval of zero seconds behaves as one second.
  assign secs      = (interval_r == '0) ? INTERVAL_BITS'(1) : interval_r;
  assign ims       = IMS_BITS'(secs * MS_PER_SEC);
  assign div_start = in_acc && (in_func == FUNC_TICK);

  ohlcv_mod_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tick_ms),
    .divisor  (ims),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Volume accumulates with one carry bit so that overflow can saturate.
  assign vol_add    = {1'b0, bar_volume_r} + (VOL_SUM_BITS + 1)'(vol_r);
  assign bar_sparse = (bar_count_r < COUNT_BITS'(min_ticks_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      interval_r   <= INTERVAL_RESET;
      min_ticks_r  <= MIN_TICKS_RESET;
      bar_active_r <= 1'b0;
      bar_start_r  <= '0;
      bar_open_r   <= '0;
      bar_high_r   <= '0;
      bar_low_r    <= '0;
      bar_close_r  <= '0;
      bar_volume_r <= '0;
      bar_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_INTERVAL:  interval_r  <= cfg_data[INTERVAL_BITS-1:0];
          CFG_MIN_TICKS: min_ticks_r <= cfg_data[MIN_TICKS_BITS-1:0];
          default: ;
        endcase
      end

      // A stalled beat stays put; a taken one leaves unless a new bar is
      // written below in the same cycle.
      out_valid_r <= out_load || (out_valid_r && out_stall);

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r  <= in_func;
            ts_r    <= in_tick_ms;
            price_r <= in_price;
            vol_r   <= in_volume;
            state_r <= (in_func == FUNC_READ) ? S_READ : S_DIV;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_ALIGN;
          end
        end

        // Bar start is the timestamp less its remainder by the interval.
        S_ALIGN: begin
          aligned_r <= ts_r - TIME_BITS'(div_rem);
          state_r   <= S_APPLY;
        end

        S_APPLY: begin
          priority if (!bar_active_r) begin
            bar_active_r <= 1'b1;
            bar_start_r  <= aligned_r;
            bar_open_r   <= price_r;
            bar_high_r   <= price_r;
            bar_low_r    <= price_r;
            bar_close_r  <= price_r;
            bar_volume_r <= VOL_SUM_BITS'(vol_r);
            bar_count_r  <= COUNT_BITS'(1);
            state_r      <= S_IDLE;
          end else if (aligned_r < bar_start_r) begin
            // A late tick belongs to a closed bar and is dropped.
            state_r <= S_IDLE;
          end else if (aligned_r > bar_start_r) begin
            // The tick opens a later bar: hand out the finished one first.
            if (slot_free) begin
              o_start_r    <= bar_start_r;
              o_open_r     <= bar_open_r;
              o_high_r     <= bar_high_r;
              o_low_r      <= bar_low_r;
              o_close_r    <= bar_close_r;
              o_volume_r   <= bar_volume_r;
              o_count_r    <= bar_count_r;
              o_sparse_r   <= bar_sparse;
              o_snapshot_r <= 1'b0;
              bar_start_r  <= aligned_r;
              bar_open_r   <= price_r;
              bar_high_r   <= price_r;
              bar_low_r    <= price_r;
              bar_close_r  <= price_r;
              bar_volume_r <= VOL_SUM_BITS'(vol_r);
              bar_count_r  <= COUNT_BITS'(1);
              state_r      <= S_IDLE;
            end
          end else begin
            if (price_r > bar_high_r) begin
              bar_high_r <= price_r;
            end
            if (price_r < bar_low_r) begin
              bar_low_r <= price_r;
            end
            bar_close_r  <= price_r;
            bar_volume_r <= vol_add[VOL_SUM_BITS] ? '1 : vol_add[VOL_SUM_BITS-1:0];
            if (bar_count_r != '1) begin
              bar_count_r <= bar_count_r + COUNT_BITS'(1);
            end
            state_r <= S_IDLE;
          end
        end

        S_READ: begin
          if (slot_free) begin
            o_snapshot_r <= 1'b1;
            if (bar_active_r) begin
              o_start_r  <= bar_start_r;
              o_open_r   <= bar_open_r;
              o_high_r   <= bar_high_r;
              o_low_r    <= bar_low_r;
              o_close_r  <= bar_close_r;
              o_volume_r <= bar_volume_r;
              o_count_r  <= bar_count_r;
              o_sparse_r <= bar_sparse;
            end else begin
              // No bar open: an empty bar, always sparse.
              o_start_r  <= '0;
              o_open_r   <= '0;
              o_high_r   <= '0;
              o_low_r    <= '0;
              o_close_r  <= '0;
              o_volume_r <= '0;
              o_count_r  <= '0;
              o_sparse_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bar_origin_ms = o_start_r;
  assign out_open_price    = o_open_r;
  assign out_high_price    = o_high_r;
  assign out_low_price     = o_low_r;
  assign out_close_price   = o_close_r;
  assign out_volume_sum    = o_volume_r;
  assign out_tick_count    = o_count_r;
  assign out_sparse        = o_sparse_r;
  assign out_snapshot      = o_snapshot_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV && func_r == FUNC_TICK))
    else $error("remainder unit finished outside the division wait");

  // The remainder unit only runs while the sequencer waits for it.
  a_div_busy_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("remainder unit running outside the division wait");

  // The aligned start never lies after the tick itself.
  a_aligned_le_ts : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> (aligned_r <= ts_r))
    else $error("aligned bar start lies after the tick timestamp");

  // An open bar always has its low at or below its high and at least one tick.
  a_bar_sane : assert property (@(posedge clk) disable iff (!rst_n)
    bar_active_r |-> (bar_low_r <= bar_high_r && bar_count_r != '0))
    else $error("open bar has an inverted range or no ticks");

  // A completed bar handed out always holds at least one tick.
  a_completed_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_snapshot_r) |-> (o_count_r != '0))
    else $error("completed bar emitted with no ticks");

endmodule
